// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; they compile away when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define GCD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition must never be true outside reset
`define GCD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define GCD_ASSERT(lbl, clk, rstn, prop, msg)
`define GCD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== src/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gcd_pkg
// Constants, types and elaboration-time tables for the haversine distance core.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int CORDIC_STAGES_DEF = 32;
    localparam int ANGLE_FRAC_BITS   = 30;

    // widths
    localparam int ANG_W  = 34;     // signed angle, 30 fraction bits
    localparam int MAG_W  = 33;     // magnitude of degree units / radians
    localparam int ROT_W  = 33;     // rotation x/y
    localparam int VEC_W  = 54;     // vectoring x/y (root lifted by 20 bits)
    localparam int ROOT_W = 32;
    localparam int RMM_W  = 33;     // radius in mm
    localparam int DIST_W = 35;

    localparam int ROOT_STEPS = 32;
    localparam int ROOT_LIFT  = 20;

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
    localparam logic [31:0] UNITS_PER_PI = 32'd1800000000;
    localparam logic [9:0]  MM_PER_M = 10'd1000;
    localparam logic [RMM_W-1:0] RMM_RESET = 33'd6371000000;

    localparam logic signed [ANG_W-1:0] PI_F      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_F = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_F  = 34'sd6746518852;
    localparam logic signed [ROT_W-1:0] ROT_ONE   = 33'sd1073741824;

    // rotation result handed from a CORDIC lane to the product stages
    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic                    flip;
    } rot_res_t;

    // atan(2^-i) in radians, 30 fraction bits, rounded
    function automatic logic signed [ANG_W-1:0] atan_f(input int i);
        logic signed [ANG_W-1:0] v;
        v = '0;
        case (i)
            0: v = 34'sd843314857;
            1: v = 34'sd497837829;
            2: v = 34'sd263043837;
            3: v = 34'sd133525159;
            4: v = 34'sd67021687;
            5: v = 34'sd33543516;
            6: v = 34'sd16775851;
            7: v = 34'sd8388437;
            8: v = 34'sd4194283;
            9: v = 34'sd2097149;
            default:
            begin
                if (i >= 10 && i <= 30)
                    v = 34'sd1 <<< (30 - i);
                else if (i == 31)
                    v = 34'sd1;
                else
                    v = '0;
            end
        endcase
        return v;
    endfunction

    // 1/P^2 of the rotation gain, 62 fraction bits, truncated
    function automatic logic [63:0] gain_sq_f(input int stages);
        logic [65:0] p;
        logic [65:0] r;
        logic [63:0] q;
        p = 66'd1 << 61;
        for (int i = 0; i < 64; i++)
            if (i < stages && 2 * i < 63)
                p = p + (p >> (2 * i));
        r = 66'd1 << 61;
        q = '0;
        for (int s = 0; s < 62; s++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= p)
            begin
                r = r - p;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // floor(pi * 2^93 / 1.8e9): degree units to radians
    function automatic logic [63:0] u2r_f();
        logic [96:0] n;
        logic [96:0] q;
        logic [32:0] rem;
        n = {PI_Q60, 33'b0};
        q = '0;
        rem = '0;
        for (int i = 96; i >= 0; i--)
        begin
            rem = {rem[31:0], n[i]};
            if (rem >= {1'b0, UNITS_PER_PI})
            begin
                rem = rem - {1'b0, UNITS_PER_PI};
                q[i] = 1'b1;
            end
        end
        return q[63:0];
    endfunction

endpackage

// ===== src/gcd_mul62.sv =====
// ----------------------------------------------------------------------------
// gcd_mul62
// 64 x 64 unsigned product shifted right by 62, two pipeline stages.
// ----------------------------------------------------------------------------
module gcd_mul62 (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] sum_next;
    logic [63:0]  p_reg;

    // partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= a[31:0]  * b[31:0];
            p01_reg <= a[31:0]  * b[63:32];
            p10_reg <= a[63:32] * b[31:0];
            p11_reg <= a[63:32] * b[63:32];
        end
    end

    // combine and take bits 125..62
    always_comb
    begin
        sum_next = {64'b0, p00_reg} + {32'b0, p01_reg, 32'b0}
                 + {32'b0, p10_reg, 32'b0} + {p11_reg, 64'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= sum_next[125:62];
    end

    assign p = p_reg;

endmodule

// ===== src/gcd_isqrt.sv =====
// ----------------------------------------------------------------------------
// gcd_isqrt
// Restoring integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module gcd_isqrt import gcd_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  logic [63:0]       v_in,
    output logic [ROOT_W-1:0] root
);

    logic [63:0] v_reg [ROOT_STEPS];
    logic [63:0] r_reg [ROOT_STEPS];

    for (genvar i = 0; i < ROOT_STEPS; i++)
    begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] vp, rp, trial;

        if (i == 0)
        begin : g_first
            assign vp = v_in;
            assign rp = '0;
        end
        else
        begin : g_next
            assign vp = v_reg[i-1];
            assign rp = r_reg[i-1];
        end

        assign trial = rp + BIT;

        // try this bit of the root
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (vp >= trial)
                begin
                    v_reg[i] <= vp - trial;
                    r_reg[i] <= (rp >> 1) + BIT;
                end
                else
                begin
                    v_reg[i] <= vp;
                    r_reg[i] <= rp >> 1;
                end
            end
        end
    end

    assign root = r_reg[ROOT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== src/gcd_rot.sv =====
// ----------------------------------------------------------------------------
// gcd_rot
// Rotation CORDIC lane: sign, range folding, then one register per iteration.
// ----------------------------------------------------------------------------
module gcd_rot import gcd_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic             clk,
    input  logic             en,
    input  logic [MAG_W-1:0] mag,
    input  logic             neg,
    output rot_res_t         res
);

    logic signed [ANG_W-1:0] t0_reg, t1_reg, t2_reg;
    logic signed [ANG_W-1:0] t1_next, t2_next;
    logic                    flip2_reg, flip2_next;

    logic signed [ROT_W-1:0] x_reg [STAGES];
    logic signed [ROT_W-1:0] y_reg [STAGES];
    logic signed [ANG_W-1:0] t_reg [STAGES];
    logic                    f_reg [STAGES];

    // fold into -pi..pi
    always_comb
    begin
        t1_next = t0_reg;
        if (t0_reg > PI_F)
            t1_next = t0_reg - TWO_PI_F;
        else if (t0_reg < -PI_F)
            t1_next = t0_reg + TWO_PI_F;
    end

    // mirror into -pi/2..pi/2, cosine flips
    always_comb
    begin
        t2_next    = t1_reg;
        flip2_next = 1'b0;
        if (t1_reg > HALF_PI_F)
        begin
            t2_next    = PI_F - t1_reg;
            flip2_next = 1'b1;
        end
        else if (t1_reg < -HALF_PI_F)
        begin
            t2_next    = -PI_F - t1_reg;
            flip2_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg    <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            flip2_reg <= flip2_next;
        end
    end

    // iterations
    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [ANG_W-1:0] ATAN = atan_f(i);
        logic signed [ROT_W-1:0] xp, yp;
        logic signed [ANG_W-1:0] tp;
        logic                    fp;

        if (i == 0)
        begin : g_first
            assign xp = ROT_ONE;
            assign yp = '0;
            assign tp = t2_reg;
            assign fp = flip2_reg;
        end
        else
        begin : g_next
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign tp = t_reg[i-1];
            assign fp = f_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (tp >= 0)
                begin
                    x_reg[i] <= xp - (yp >>> i);
                    y_reg[i] <= yp + (xp >>> i);
                    t_reg[i] <= tp - ATAN;
                end
                else
                begin
                    x_reg[i] <= xp + (yp >>> i);
                    y_reg[i] <= yp - (xp >>> i);
                    t_reg[i] <= tp + ATAN;
                end
                f_reg[i] <= fp;
            end
        end
    end

    assign res.x    = x_reg[STAGES-1];
    assign res.y    = y_reg[STAGES-1];
    assign res.flip = f_reg[STAGES-1];

endmodule

// ===== src/gcd_vec.sv =====
// ----------------------------------------------------------------------------
// gcd_vec
// Vectoring CORDIC: atan2(yr, xr) for nonnegative roots, pipelined.
// ----------------------------------------------------------------------------
module gcd_vec import gcd_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic              clk,
    input  logic              en,
    input  logic [ROOT_W-1:0] xr,
    input  logic [ROOT_W-1:0] yr,
    output logic [ANG_W-2:0]  z
);

    logic signed [VEC_W-1:0] x_reg [STAGES];
    logic signed [VEC_W-1:0] y_reg [STAGES];
    logic signed [ANG_W-1:0] z_reg [STAGES];
    logic                    zx_reg [STAGES];
    logic                    zy_reg [STAGES];
    logic [ANG_W-2:0]        z_out_reg;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [ANG_W-1:0] ATAN = atan_f(i);
        logic signed [VEC_W-1:0] xp, yp;
        logic signed [ANG_W-1:0] zp;
        logic                    zxp, zyp;

        if (i == 0)
        begin : g_first
            assign xp  = $signed({2'b0, xr, {ROOT_LIFT{1'b0}}});
            assign yp  = $signed({2'b0, yr, {ROOT_LIFT{1'b0}}});
            assign zp  = '0;
            assign zxp = (xr == '0);
            assign zyp = (yr == '0);
        end
        else
        begin : g_next
            assign xp  = x_reg[i-1];
            assign yp  = y_reg[i-1];
            assign zp  = z_reg[i-1];
            assign zxp = zx_reg[i-1];
            assign zyp = zy_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (yp >= 0)
                begin
                    x_reg[i] <= xp + (yp >>> i);
                    y_reg[i] <= yp - (xp >>> i);
                    z_reg[i] <= zp + ATAN;
                end
                else
                begin
                    x_reg[i] <= xp - (yp >>> i);
                    y_reg[i] <= yp + (xp >>> i);
                    z_reg[i] <= zp - ATAN;
                end
                zx_reg[i] <= zxp;
                zy_reg[i] <= zyp;
            end
        end
    end

    // zero sine root gives 0, zero cosine root gives pi/2, negative clamps to 0
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zy_reg[STAGES-1] || z_reg[STAGES-1] < 0)
                z_out_reg <= '0;
            else if (zx_reg[STAGES-1])
                z_out_reg <= HALF_PI_F[ANG_W-2:0];
            else
                z_out_reg <= z_reg[STAGES-1][ANG_W-2:0];
        end
    end

    assign z = z_out_reg;

endmodule

// ===== src/great_circle_distance_core.sv =====
// ----------------------------------------------------------------------------
// great_circle_distance_core
// Haversine great-circle distance in mm between two lat/lon positions.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the CORDIC lanes, root and multiplier stages
// are fully pipelined and stall together only when the output skid is full.
// Reset clears all valid flags and sets the radius to 6371000 m.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module great_circle_distance_core import gcd_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [22:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [30:0] first_lat,
    input  logic signed [31:0] first_lon,
    input  logic signed [30:0] second_lat,
    input  logic signed [31:0] second_lon,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DIST_W-1:0]  distance_mm
);

    localparam logic [63:0] U2R  = u2r_f();
    localparam logic [63:0] GAIN = gain_sq_f(CORDIC_STAGES);
    localparam int VL = 2 * CORDIC_STAGES + 48;

    // control
    logic          adv;
    logic [VL-1:0] vld_reg;
    logic          out_valid_reg, skid_valid_reg;
    logic          out_free;
    logic [RMM_W-1:0] rmm_reg;

    // front end: magnitudes and radians
    logic signed [MAG_W-1:0] ang_w [4];
    logic [MAG_W-1:0] p1_mag_reg [4];
    logic             p1_neg_reg [4];
    logic [64:0]      p2_lo_reg [4];
    logic [64:0]      p2_hi_reg [4];
    logic             p2_neg_reg [4];
    logic [96:0]      full_w [4];
    logic [MAG_W-1:0] p3_mag_reg [4];
    logic             p3_neg_reg [4];
    rot_res_t         rot_res [4];

    // products
    logic signed [ROT_W-1:0] cx1_w, cx2_w;
    logic [ROT_W-1:0] abs_w [4];
    logic             nc1_w, nc2_w;
    logic [31:0]      m_reg [4];
    logic             neg_reg;
    logic [4:0]       neg_d_reg;
    logic [63:0]      sq1_reg, c12_reg, sq2_reg;
    logic [63:0]      t1_w, gc_w, gs_w, t2_w;
    logic [63:0]      t1_d_reg [2];
    logic [63:0]      a_reg;
    logic [63:0]      ha_reg, onem_reg;
    logic [ROOT_W-1:0] rx_w, ry_w;
    logic [ANG_W-2:0] z_w;
    logic [66:0]      prod_reg;
    logic [DIST_W-1:0] out_data_reg, skid_data_reg;

    assign adv      = !skid_valid_reg;
    assign in_ready = adv;

    // radius register, stored in mm
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rmm_reg <= RMM_RESET;
        else if (cfg_we)
            rmm_reg <= {10'b0, cfg_wdata} * {23'b0, MM_PER_M};
    end

    // valid flags follow the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[VL-2:0], in_valid};
    end

    // stage 1: latitudes and half-difference operands, as sign and magnitude
    always_comb
    begin
        ang_w[0] = MAG_W'(first_lat);
        ang_w[1] = MAG_W'(second_lat);
        ang_w[2] = MAG_W'(second_lat) - MAG_W'(first_lat);
        ang_w[3] = MAG_W'(second_lon) - MAG_W'(first_lon);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p1_neg_reg[k] <= ang_w[k] < 0;
                p1_mag_reg[k] <= ang_w[k] < 0 ? MAG_W'(-ang_w[k]) : MAG_W'(ang_w[k]);
            end
        end
    end

    // stage 2: partial products with the radian scale
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p2_lo_reg[k]  <= {32'b0, p1_mag_reg[k]} * {33'b0, U2R[31:0]};
                p2_hi_reg[k]  <= {32'b0, p1_mag_reg[k]} * {33'b0, U2R[63:32]};
                p2_neg_reg[k] <= p1_neg_reg[k];
            end
        end
    end

    // stage 3: sum and scale (half differences shift one more)
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            full_w[k] = {32'b0, p2_lo_reg[k]} + {p2_hi_reg[k], 32'b0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_mag_reg[0] <= full_w[0][95:63];
            p3_mag_reg[1] <= full_w[1][95:63];
            p3_mag_reg[2] <= full_w[2][96:64];
            p3_mag_reg[3] <= full_w[3][96:64];
            for (int k = 0; k < 4; k++)
                p3_neg_reg[k] <= p2_neg_reg[k];
        end
    end

    // four rotation lanes: cos lat1, cos lat2, sin dlat/2, sin dlon/2
    for (genvar k = 0; k < 4; k++)
    begin : g_rot
        gcd_rot #(
            .STAGES (CORDIC_STAGES)
        ) u_rot (
            .clk (clk),
            .en  (adv),
            .mag (p3_mag_reg[k]),
            .neg (p3_neg_reg[k]),
            .res (rot_res[k])
        );
    end

    // magnitudes and sign of the cosine product
    always_comb
    begin
        cx1_w = rot_res[0].x;
        cx2_w = rot_res[1].x;
        abs_w[0] = cx1_w < 0 ? ROT_W'(-cx1_w) : ROT_W'(cx1_w);
        abs_w[1] = cx2_w < 0 ? ROT_W'(-cx2_w) : ROT_W'(cx2_w);
        abs_w[2] = rot_res[2].y < 0 ? ROT_W'(-rot_res[2].y) : ROT_W'(rot_res[2].y);
        abs_w[3] = rot_res[3].y < 0 ? ROT_W'(-rot_res[3].y) : ROT_W'(rot_res[3].y);
        nc1_w = rot_res[0].flip ? (cx1_w > 0) : (cx1_w < 0);
        nc2_w = rot_res[1].flip ? (cx2_w > 0) : (cx2_w < 0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
                m_reg[k] <= abs_w[k][31:0];
            neg_reg   <= nc1_w ^ nc2_w;
            neg_d_reg <= {neg_d_reg[3:0], neg_reg};
        end
    end

    // squares and cosine product at 62 fraction bits (full 64-bit products)
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq1_reg <= ({32'b0, m_reg[2]} * {32'b0, m_reg[2]}) << 2;
            c12_reg <= ({32'b0, m_reg[0]} * {32'b0, m_reg[1]}) << 2;
            sq2_reg <= ({32'b0, m_reg[3]} * {32'b0, m_reg[3]}) << 2;
        end
    end

    // remove the CORDIC gain
    gcd_mul62 u_mul_t1 (.clk(clk), .en(adv), .a(sq1_reg), .b(GAIN), .p(t1_w));
    gcd_mul62 u_mul_gc (.clk(clk), .en(adv), .a(c12_reg), .b(GAIN), .p(gc_w));
    gcd_mul62 u_mul_gs (.clk(clk), .en(adv), .a(sq2_reg), .b(GAIN), .p(gs_w));
    gcd_mul62 u_mul_t2 (.clk(clk), .en(adv), .a(gc_w),    .b(gs_w), .p(t2_w));

    // haversine term, saturated to 0..1
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_d_reg[0] <= t1_w;
            t1_d_reg[1] <= t1_d_reg[0];
            if (!neg_d_reg[4])
                a_reg <= t1_d_reg[1] + t2_w;
            else
                a_reg <= t1_d_reg[1] > t2_w ? t1_d_reg[1] - t2_w : '0;
            ha_reg   <= a_reg > ONE_Q62 ? ONE_Q62 : a_reg;
            onem_reg <= a_reg > ONE_Q62 ? '0 : ONE_Q62 - a_reg;
        end
    end

    gcd_isqrt u_sqrt_x (.clk(clk), .en(adv), .v_in(onem_reg), .root(rx_w));
    gcd_isqrt u_sqrt_y (.clk(clk), .en(adv), .v_in(ha_reg),   .root(ry_w));

    gcd_vec #(
        .STAGES (CORDIC_STAGES)
    ) u_vec (
        .clk (clk),
        .en  (adv),
        .xr  (rx_w),
        .yr  (ry_w),
        .z   (z_w)
    );

    // 2c times radius in mm
    always_ff @(posedge clk)
    begin
        if (adv)
            prod_reg <= {33'b0, z_w, 1'b0} * {34'b0, rmm_reg};
    end

    // output register with one skid entry
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= vld_reg[VL-1];
        end
        else if (!skid_valid_reg && vld_reg[VL-1])
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_data_reg <= skid_valid_reg ? skid_data_reg : prod_reg[64:30];
        else if (!skid_valid_reg)
            skid_data_reg <= prod_reg[64:30];
    end

    assign out_valid   = out_valid_reg;
    assign distance_mm = out_data_reg;

    // checks
    `GCD_ASSERT_NEVER(a_skid_without_out, clk, rst_n, skid_valid_reg && !out_valid_reg, "skid holds an item while output is empty")
    `GCD_ASSERT(a_skid_drains, clk, rst_n, (skid_valid_reg && out_ready) |=> !skid_valid_reg, "skid not drained after output taken")
    `GCD_ASSERT(a_stall_holds, clk, rst_n, !in_ready |=> $stable(vld_reg), "pipeline moved during stall")

endmodule

// ===== bench/tb_great_circle_distance_core.sv =====
// ----------------------------------------------------------------------------
// tb_great_circle_distance_core
// Self-checking bench for the haversine distance core.
// Position pairs stream in over valid/ready while a bit-exact fixed-point
// model in this file predicts each distance. The checker compares every
// output item with the oldest prediction. The radius register is swept
// between phases, and both sides idle at random or hold off on purpose.
// ----------------------------------------------------------------------------
module tb_great_circle_distance_core;
    import gcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_STAGES  = 32;
    localparam int FRAC        = 30;
    localparam int PIPE_DRAIN  = 200;   // beyond the pipeline latency
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 600;
    localparam logic [63:0] Q62_ONE = 64'h4000000000000000;
    localparam logic [63:0] PI_Q60_BITS = 64'h3243F6A8885A308D;
    localparam logic [22:0] RADIUS_EARTH = 23'd6371000;
    localparam logic [22:0] RADIUS_MIN = 23'd1;
    localparam logic [22:0] RADIUS_MAX = 23'd8388607;
    localparam longint LAT_MAX = 900000000;
    localparam longint LON_MAX = 1800000000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [22:0]        cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic signed [30:0] first_lat;
    logic signed [31:0] first_lon;
    logic signed [30:0] second_lat;
    logic signed [31:0] second_lon;
    logic               out_valid;
    logic               out_ready;
    logic [DIST_W-1:0]  distance_mm;

    great_circle_distance_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .first_lat  (first_lat),
        .first_lon  (first_lon),
        .second_lat (second_lat),
        .second_lon (second_lon),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .distance_mm(distance_mm)
    );

    // model constants and the radius copy
    longint      arctan_q[NUM_STAGES];
    logic [63:0] inv_gain_sq;
    logic [63:0] deg_to_rad;
    longint      pi_q, half_pi_q, two_pi_q;
    logic [22:0] radius_m;

    logic [DIST_W-1:0] distance_queue[$];
    int  mismatches;
    int  items_sent;
    int  items_checked;
    int  stall_count;
    bit  calm_sender;
    bit  calm_receiver;
    int  hold_request;

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // unsigned 64x64 product shifted right by s, low 64 bits kept
    function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    function automatic void build_constants();
        logic [63:0] acc, term, p, r, q;
        logic [127:0] wide;
        arctan_q[0] = longint'((PI_Q60_BITS + 64'd2147483648) >> 32);
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            acc = '0;
            for (int k = 0; i * (2 * k + 1) <= 62; k++)
            begin
                term = (Q62_ONE >> (i * (2 * k + 1))) / (2 * k + 1);
                if (k % 2 == 1) acc = acc - term;
                else acc = acc + term;
            end
            arctan_q[i] = longint'((acc + 64'd2147483648) >> 32);
        end
        p = 64'd1 << 61;
        for (int i = 0; i < NUM_STAGES; i++)
            if (2 * i < 63) p = p + (p >> (2 * i));
        r = 64'd1 << 61;
        q = '0;
        for (int s = 0; s < 62; s++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= p)
            begin
                r = r - p;
                q[0] = 1'b1;
            end
        end
        inv_gain_sq = q;
        wide = {64'b0, PI_Q60_BITS} << 33;
        wide = wide / 128'd1800000000;
        deg_to_rad = wide[63:0];
        pi_q      = longint'((PI_Q60_BITS + (64'd1 << 29)) >> 30);
        half_pi_q = longint'((PI_Q60_BITS + (64'd1 << 30)) >> 31);
        two_pi_q  = longint'((PI_Q60_BITS + (64'd1 << 28)) >> 29);
    endfunction

    function automatic longint units_to_angle(input longint units, input int shift);
        logic [63:0] mag;
        longint r;
        mag = (units < 0) ? -units : units;
        r = longint'(mul_shr(mag, deg_to_rad, shift));
        return (units < 0) ? -r : r;
    endfunction

    // rotation CORDIC, gain left in
    function automatic void sin_cos(input longint ang, output longint cv, output longint sv);
        longint x, y, xs, ys, t;
        bit flip;
        t = ang;
        x = longint'(1) << FRAC;
        y = 0;
        flip = 1'b0;
        if (t > pi_q) t = t - two_pi_q;
        else if (t < -pi_q) t = t + two_pi_q;
        if (t > half_pi_q)
        begin
            t = pi_q - t;
            flip = 1'b1;
        end
        else if (t < -half_pi_q)
        begin
            t = -pi_q - t;
            flip = 1'b1;
        end
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (t >= 0)
            begin
                x = x - ys;
                y = y + xs;
                t = t - arctan_q[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                t = t + arctan_q[i];
            end
        end
        cv = flip ? -x : x;
        sv = y;
    endfunction

    function automatic logic [63:0] to_q62(input longint v);
        logic [63:0] m;
        m = (v < 0) ? -v : v;
        return m << (62 - FRAC);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv, rem;
        res = '0;
        rem = v;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // vectoring CORDIC: angle of (xr, yr)
    function automatic longint atan_of(input logic [63:0] xr, input logic [63:0] yr);
        longint x, y, z, xs, ys;
        if (yr == 0) return 0;
        if (xr == 0) return half_pi_q;
        x = longint'(xr << 20);
        y = longint'(yr << 20);
        z = 0;
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_q[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_q[i];
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    function automatic logic [DIST_W-1:0] haversine_mm(input longint lat1, input longint lon1,
                                                      input longint lat2, input longint lon2);
        longint c1, c2, s1, s2, unused, z;
        logic [63:0] t1, t2, hav, dist_full;
        sin_cos(units_to_angle(lat1, 93 - FRAC), c1, unused);
        sin_cos(units_to_angle(lat2, 93 - FRAC), c2, unused);
        sin_cos(units_to_angle(lat2 - lat1, 94 - FRAC), unused, s1);
        sin_cos(units_to_angle(lon2 - lon1, 94 - FRAC), unused, s2);
        t1 = mul_shr(mul_shr(to_q62(s1), to_q62(s1), 62), inv_gain_sq, 62);
        t2 = mul_shr(mul_shr(mul_shr(to_q62(c1), to_q62(c2), 62), inv_gain_sq, 62),
                     mul_shr(mul_shr(to_q62(s2), to_q62(s2), 62), inv_gain_sq, 62), 62);
        if ((c1 < 0) == (c2 < 0)) hav = t1 + t2;
        else hav = (t1 > t2) ? t1 - t2 : '0;
        if (hav > Q62_ONE) hav = Q62_ONE;
        z = atan_of(int_sqrt(Q62_ONE - hav), int_sqrt(hav));
        dist_full = mul_shr(64'(z) * 2, 64'(radius_m) * 64'd1000, FRAC);
        return dist_full[DIST_W-1:0];
    endfunction

    // one position pair; returns just after the accepting edge
    task automatic send_pair(input longint lat1, input longint lon1,
                             input longint lat2, input longint lon2);
        in_valid   <= 1'b1;
        first_lat  <= 31'(lat1);
        first_lon  <= 32'(lon1);
        second_lat <= 31'(lat2);
        second_lon <= 32'(lon2);
        do @(posedge clk); while (!in_ready);
        distance_queue.push_back(haversine_mm(lat1, lon1, lat2, lon2));
        items_sent++;
    endtask

    task automatic maybe_idle();
        int n;
        if (!calm_sender && $urandom_range(0, 99) < 23)
        begin
            n = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // block fully drained; safe for a register write
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (distance_queue.size() != 0) @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_radius(input logic [22:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        radius_m = value;
    endtask

    function automatic longint rand_lat();
        return longint'($urandom_range(0, 1800000000)) - LAT_MAX;
    endfunction

    function automatic longint rand_lon();
        return longint'($urandom_range(0, 32'd3600000000)) - LON_MAX;
    endfunction

    // extremes, coincident points, antipodes, angle wrap
    task automatic test_directed();
        send_pair(0, 0, 0, 0);
        send_pair(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_pair(0, -LON_MAX, 0, LON_MAX);
        send_pair(0, LON_MAX, 0, -LON_MAX);
        send_pair(123456789, 0, -123456789, LON_MAX);
        send_pair(LAT_MAX, 0, LAT_MAX, LON_MAX);
        send_pair(-LAT_MAX, LON_MAX, 0, 0);
        send_pair(0, 0, 0, 1);
        send_pair(0, 0, 1, 0);
        send_pair(0, 0, 0, -1);
        send_pair(-1, -1, 1, 1);
        send_pair(0, 0, 0, 900000000);
        send_pair(0, -900000000, 0, 900000000);
        send_pair(0, 900000001, 0, -900000001);
        send_pair(450000000, 1000000000, -450000000, -800000000);
        send_pair(LAT_MAX, -LON_MAX, LAT_MAX - 1, LON_MAX);
        send_pair(-LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
        send_pair(LAT_MAX - 1, LON_MAX - 1, -LAT_MAX + 1, -LON_MAX + 1);
        wait_idle();
    endtask

    // random pairs, some close together, some antipodal
    task automatic test_random(input int count);
        longint la, lo, lb, lb2;
        for (int i = 0; i < count; i++)
        begin
            calm_sender = (i >= count / 3) && (i < count / 3 + 60);
            la = rand_lat();
            lo = rand_lon();
            case ($urandom_range(0, 3))
                0:
                begin
                    lb = la + longint'($urandom_range(0, 2000)) - 1000;
                    lb2 = lo + longint'($urandom_range(0, 2000)) - 1000;
                    if (lb > LAT_MAX || lb < -LAT_MAX) lb = la;
                    if (lb2 > LON_MAX || lb2 < -LON_MAX) lb2 = lo;
                    send_pair(la, lo, lb, lb2);
                end
                1:
                begin
                    lb2 = (lo > 0) ? lo - LON_MAX : lo + LON_MAX;
                    send_pair(la, lo, -la, lb2);
                end
                default: send_pair(la, lo, rand_lat(), rand_lon());
            endcase
            maybe_idle();
        end
        calm_sender = 1'b0;
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 200; i++)
            send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
        wait_idle();
    endtask

    // sender pauses until every distance is back, then resumes
    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++)
            send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
        in_valid <= 1'b0;
        while (distance_queue.size() != 0) @(posedge clk);
        for (int i = 0; i < 20; i++)
        begin
            send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
            maybe_idle();
        end
        wait_idle();
    endtask

    // receiver: random stalls, forced hold-off, result checking
    initial
    begin
        logic [DIST_W-1:0] want;
        int held;
        out_ready <= 1'b0;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (distance_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected distance item %0d", distance_mm);
                end
                else
                begin
                    want = distance_queue.pop_front();
                    items_checked++;
                    if (distance_mm !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("distance_mm mismatch: expected %0d, got %0d",
                                     want, distance_mm);
                    end
                end
            end
            if (hold_request > 0)
            begin
                held = hold_request;
                hold_request = 0;
            end
            if (held > 0)
            begin
                held--;
                out_ready <= 1'b0;
            end
            else if (calm_receiver)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 23);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_count <= 0;
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            stall_count <= stall_count + 1;
    end

    initial
    begin
        mismatches = 0;
        items_sent = 0;
        items_checked = 0;
        stall_count = 0;
        calm_sender = 1'b0;
        calm_receiver = 1'b0;
        hold_request = 0;
        build_constants();
        radius_m   = RADIUS_EARTH;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        first_lat  = '0;
        first_lon  = '0;
        second_lat = '0;
        second_lon = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_radius(RADIUS_MAX);
        test_directed();
        write_radius(RADIUS_MIN);
        test_directed();
        write_radius(RADIUS_EARTH);
        test_random(200);
        test_backpressure();
        write_radius(23'($urandom_range(1, 8388607)));
        calm_receiver = 1'b1;
        test_random(75);
        calm_receiver = 1'b0;
        write_radius(RADIUS_MAX);
        test_random(75);
        test_drain_pause();

        wait_idle();
        $display("covered %0d position pairs, %0d distances checked, 4 radius settings",
                 items_sent, items_checked);
        $display("included extremes, antipodes, coincident points and a long output stall");
        if (mismatches == 0 && distance_queue.size() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches, %0d outstanding", mismatches, distance_queue.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/gcd_pkg.sv
src/gcd_mul62.sv
src/gcd_isqrt.sv
src/gcd_rot.sv
src/gcd_vec.sv
src/great_circle_distance_core.sv
bench/tb_great_circle_distance_core.sv
